// ----- rtl/core/lrupr_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement package
// Sizes, result record and the priority encoder shared by the tracker.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS  = 16;
	localparam int SLOT_W     = 4;
	localparam int CFG_W      = 5;
	localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
	localparam int TALLY_W    = 16;

	localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

	typedef logic [PAGE_BITS-1:0]  page_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [SLOT_W-1:0]     rank_t;
	typedef logic [MAX_FRAMES-1:0] frame_vec_t;

	typedef struct packed {
		logic                 was_hit;
		slot_t                frame_slot;
		logic                 evicted_valid;
		page_t                evicted_page;
		logic [TALLY_W-1:0]   fault_total;
	} rsp_t;

	function automatic slot_t first_set(input frame_vec_t vec);
		slot_t idx;
		idx = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (vec[i]) idx = SLOT_W'(i);
		end
		return idx;
	endfunction

endpackage

// ----- rtl/core/lrupr_if.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement channels
// Request, result and frame count channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lrupr_req_if import lrupr_pkg::*; ();
	logic  valid;
	logic  ready;
	page_t page_number;
	logic  end_of_string;

	modport source (output valid, page_number, end_of_string, input ready);
	modport sink   (input valid, page_number, end_of_string, output ready);
endinterface

interface lrupr_rsp_if import lrupr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 was_hit;
	slot_t                frame_slot;
	logic                 evicted_valid;
	page_t                evicted_page;
	logic [TALLY_W-1:0]   fault_total;

	modport source (output valid, was_hit, frame_slot, evicted_valid, evicted_page,
		fault_total, input ready);
	modport sink   (input valid, was_hit, frame_slot, evicted_valid, evicted_page,
		fault_total, output ready);
endinterface

interface lrupr_cfg_if import lrupr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] frames_in_use;

	modport source (output valid, frames_in_use, input ready);
	modport sink   (input valid, frames_in_use, output ready);
endinterface

// ----- rtl/core/lru_page_replacement_top.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement tracker
// Fully associative LRU frame tracker, one page reference per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one page reference per request (page_number, end_of_string).
//   rsp  : one result per request: hit flag, frame slot, evicted page and
//          the running fault count of the current string.
//   cfg  : write-only frame count; always ready, write only while idle.
// The request lands in an input register, then one pass of parallel tag
// compare, LRU rank compare and rank update fills the result register and
// updates the frame state; rsp.valid rises when the result register is
// loaded. Throughput is one request per cycle while rsp does not stall;
// the frame state written by one request is seen by the next in the
// following cycle.
// When rsp stalls, the result register holds, the input register holds one
// more request, and req.ready drops. Reset empties all frames, clears the
// fault count and sets the frame count to four. end_of_string empties the
// frames and clears the fault count after its own result.
// ----------------------------------------------------------------------------
module lru_page_replacement_top import lrupr_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	lrupr_req_if.sink    req,
	lrupr_rsp_if.source  rsp,
	lrupr_cfg_if.sink    cfg
);

	logic [CFG_W-1:0]   frames_q;
	logic               valid_s1;
	page_t              page_s1;
	logic               eos_s1;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	page_t              slot_page_q [MAX_FRAMES];
	rank_t              rank_q      [MAX_FRAMES];
	frame_vec_t         slot_valid_q;
	logic [TALLY_W-1:0] tally_q;

	logic               advance;
	logic [COUNT_W-1:0] count_c;
	frame_vec_t         use_c, hit_vec, empty_vec, lru_vec;
	logic               hit_c, any_empty_c, evict_c, was_valid_c;
	slot_t              slot_c;
	rank_t              old_rank_c;
	rank_t              rank_n [MAX_FRAMES];
	frame_vec_t         valid_n;
	logic [TALLY_W-1:0] tally_n;
	rsp_t               rsp_n;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= CFG_W'(4);
		end else if (cfg.valid) begin
			frames_q <= cfg.frames_in_use;
		end
	end

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			page_s1 <= req.page_number;
			eos_s1  <= req.end_of_string;
		end
	end

	always_comb begin
		if (frames_q == '0) begin
			count_c = COUNT_W'(1);
		end else if (COUNT_W'(frames_q) > COUNT_W'(MAX_FRAMES)) begin
			count_c = COUNT_W'(MAX_FRAMES);
		end else begin
			count_c = COUNT_W'(frames_q);
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_FRAMES; j++) begin
			use_c[j]     = COUNT_W'(j) < count_c;
			hit_vec[j]   = use_c[j] && slot_valid_q[j] && (slot_page_q[j] == page_s1);
			empty_vec[j] = use_c[j] && !slot_valid_q[j];
		end
		for (int j = 0; j < MAX_FRAMES; j++) begin
			lru_vec[j] = use_c[j];
			for (int k = 0; k < MAX_FRAMES; k++) begin
				if (use_c[k] && (rank_q[k] > rank_q[j])) lru_vec[j] = 1'b0;
			end
		end
	end

	always_comb begin
		hit_c       = |hit_vec;
		any_empty_c = |empty_vec;
		evict_c     = !hit_c && !any_empty_c;
		if (hit_c) begin
			slot_c = first_set(hit_vec);
		end else if (any_empty_c) begin
			slot_c = first_set(empty_vec);
		end else begin
			slot_c = first_set(lru_vec);
		end
		was_valid_c = slot_valid_q[slot_c];
		old_rank_c  = rank_q[slot_c];

		for (int k = 0; k < MAX_FRAMES; k++) begin
			if (SLOT_W'(k) == slot_c) begin
				rank_n[k] = '0;
			end else if (slot_valid_q[k] && (!was_valid_c || rank_q[k] < old_rank_c)) begin
				rank_n[k] = rank_q[k] + rank_t'(1);
			end else begin
				rank_n[k] = rank_q[k];
			end
		end
		valid_n         = slot_valid_q;
		valid_n[slot_c] = 1'b1;

		if (hit_c || tally_q == TALLY_MAX) begin
			tally_n = tally_q;
		end else begin
			tally_n = tally_q + TALLY_W'(1);
		end

		rsp_n.was_hit       = hit_c;
		rsp_n.frame_slot    = slot_c;
		rsp_n.evicted_valid = evict_c;
		rsp_n.evicted_page  = evict_c ? slot_page_q[slot_c] : '0;
		rsp_n.fault_total   = tally_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			tally_q      <= '0;
			for (int j = 0; j < MAX_FRAMES; j++) begin
				rank_q[j]      <= '0;
				slot_page_q[j] <= '0;
			end
		end else if (advance) begin
			slot_valid_q <= eos_s1 ? '0 : valid_n;
			tally_q      <= eos_s1 ? '0 : tally_n;
			for (int j = 0; j < MAX_FRAMES; j++) begin
				rank_q[j] <= rank_n[j];
			end
			if (!hit_c) begin
				slot_page_q[slot_c] <= page_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.was_hit       = rsp_q.was_hit;
	assign rsp.frame_slot    = rsp_q.frame_slot;
	assign rsp.evicted_valid = rsp_q.evicted_valid;
	assign rsp.evicted_page  = rsp_q.evicted_page;
	assign rsp.fault_total   = rsp_q.fault_total;

`ifndef SYNTH
	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid_q && !rsp.ready |-> !req.ready)
		else $error("request taken while result stage is stalled");

	a_frames_only_fill: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !eos_s1 |=>
		$countones(slot_valid_q) >= $past($countones(slot_valid_q)))
		else $error("frame emptied outside end of string");

	a_tally_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !eos_s1 && !hit_c && tally_q != TALLY_MAX |=>
		tally_q == $past(tally_q) + TALLY_W'(1))
		else $error("fault count did not advance on a miss");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> !(rsp_q.was_hit && rsp_q.evicted_valid))
		else $error("hit reported with an eviction");
`endif

endmodule
